>>> hdl/fdh_pkg.sv
`timescale 1ns / 1ps

package fdh_pkg;

  // One RGB pixel as it sits in the background store: red in the top byte.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam int INDEX_W = 17;
  localparam logic [7:0] TOLERANCE_RESET = 8'd10;

  // Change markers per channel.
  localparam logic [7:0] MARK_BRIGHTER = 8'hFF;
  localparam logic [7:0] MARK_DARKER   = 8'h7F;
  localparam logic [7:0] MARK_NONE     = 8'h00;

  // Result queue between the compute stage and the output port.
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_CNT_W = 2;
  localparam int OUTQ_PTR_W = 2;

endpackage

>>> hdl/frame_difference_highlighter.sv
// Frame difference highlighter. Each input transfer carries one RGB pixel and
// its raster position; each one yields exactly one output transfer holding a
// per-channel change marker (0 no change, 127 darker or equal, 255 brighter),
// judged against the background pixel stored at that position and the
// programmable tolerance (reset value 10). The background entry is then
// replaced by the per-channel floor average of old and new. Positions at or
// beyond FRAME_PIXELS compare against zero and leave the store untouched.
// After the clearing sweep and while out_stall is low, the block sustains one
// pixel per clock: a pixel reads the background memory (one read port and one
// write port) in the cycle it is accepted, is marked and written back in the
// next cycle, and its result enters a three-entry output queue.
// Back-to-back pixels at the same position are handled by forwarding the
// value just written. After reset the background memory is swept to zero,
// one entry per clock, so in_stall stays high until every entry has been
// cleared; the tolerance register can be written during that time. Tolerance
// should only be changed while no pixels are in flight.
`timescale 1ns / 1ps

module frame_difference_highlighter import fdh_pkg::*; #(
  parameter int FRAME_PIXELS = 131072
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [INDEX_W-1:0] pixel_index,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  logic [7:0] tolerance;

  // Input side: a transfer launches the background read right away.
  logic          in_fire;
  logic          in_ok;
  logic [AW-1:0] in_addr;
  rgb_t          in_pix;

  // Compute stage, in the cycle after the read.
  logic          s1_valid;
  logic          s1_ok;
  logic [AW-1:0] s1_addr;
  rgb_t          s1_pix;

  // Last write-back, held in registers to cover a read that raced it.
  logic          wb_valid;
  logic [AW-1:0] wb_addr;
  rgb_t          wb_data;

  rgb_t rd_data;
  rgb_t old_pix;
  rgb_t mark;
  rgb_t avg;
  logic clearing;
  logic wr_en;

  logic                  q_pop;
  rgb_t                  q_head;
  logic [OUTQ_CNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  // Hold off input while the store is being cleared, or while the queue could
  // not absorb the pixel in the compute stage plus a new one.
  assign in_stall = clearing ||
                    ((3'(q_count) + 3'(s1_valid)) >= 3'(OUTQ_DEPTH));
  assign in_fire  = in_valid && !in_stall;
  assign in_ok    = 32'(pixel_index) < 32'(FRAME_PIXELS);
  assign in_addr  = AW'(pixel_index);
  assign in_pix   = '{red: in_red, green: in_green, blue: in_blue};

  fdh_bg_store #(
    .DEPTH (FRAME_PIXELS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_fire),
    .rd_addr  (in_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (s1_addr),
    .wr_data  (avg),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
      wb_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ok   <= in_ok;
      s1_addr <= in_addr;
      s1_pix  <= in_pix;
    end
    wb_addr <= s1_addr;
    wb_data <= avg;
  end

  // An out-of-range pixel compares against black. An in-range pixel whose read
  // happened in the same cycle as a write to its entry takes the written value.
  always_comb begin
    priority if (!s1_ok) begin
      old_pix = '0;
    end else if (wb_valid && (wb_addr == s1_addr)) begin
      old_pix = wb_data;
    end else begin
      old_pix = rd_data;
    end
  end

  fdh_mark u_mark (
    .now_pix   (s1_pix),
    .old_pix   (old_pix),
    .tolerance (tolerance),
    .mark      (mark),
    .avg       (avg)
  );

  assign wr_en = s1_valid && s1_ok;

  assign q_pop = out_valid && !out_stall;

  fdh_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (mark),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (out_valid),
    .count     (q_count)
  );

  assign out_red   = q_head.red;
  assign out_green = q_head.green;
  assign out_blue  = q_head.blue;

`ifndef SYNTHESIS
  // The input hold-off must keep the queue from ever being pushed when full.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (q_count != OUTQ_CNT_W'(OUTQ_DEPTH)))
    else $error("result pushed into a full output queue");

  // Nothing may be in flight while the background sweep owns the store.
  a_idle_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_valid && (q_count == '0) && !out_valid))
    else $error("pixel in flight during background clearing");

  // Queue occupancy tracks compute-stage pushes and output transfers.
  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (3'(q_count) ==
      3'($past(q_count)) + 3'($past(s1_valid)) - 3'($past(q_pop))))
    else $error("output queue occupancy out of step");
`endif

endmodule

>>> hdl/fdh_bg_store.sv
`timescale 1ns / 1ps

module fdh_bg_store import fdh_pkg::*; #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rgb_t          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rgb_t          wr_data,
  output logic          clearing
);

  rgb_t          mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rgb_t          mem_wdata;

  // The clearing sweep owns the write port until every entry holds zero.
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

endmodule

>>> hdl/fdh_mark.sv
`timescale 1ns / 1ps

module fdh_mark import fdh_pkg::*; (
  input  rgb_t       now_pix,
  input  rgb_t       old_pix,
  input  logic [7:0] tolerance,
  output rgb_t       mark,
  output rgb_t       avg
);

  function automatic logic [7:0] chan_mark(input logic [7:0] now_v, input logic [7:0] old_v,
                                           input logic [7:0] tol);
    logic [7:0] diff;
    logic [7:0] sel;
    begin
      if (now_v > old_v) begin
        diff = now_v - old_v;
        sel  = MARK_BRIGHTER;
      end else begin
        diff = old_v - now_v;
        sel  = MARK_DARKER;
      end
      chan_mark = (diff >= tol) ? sel : MARK_NONE;
    end
  endfunction

  function automatic logic [7:0] chan_avg(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    begin
      sum      = {1'b0, a} + {1'b0, b};
      chan_avg = sum[8:1];
    end
  endfunction

  always_comb begin
    mark.red   = chan_mark(now_pix.red,   old_pix.red,   tolerance);
    mark.green = chan_mark(now_pix.green, old_pix.green, tolerance);
    mark.blue  = chan_mark(now_pix.blue,  old_pix.blue,  tolerance);
    avg.red    = chan_avg(now_pix.red,   old_pix.red);
    avg.green  = chan_avg(now_pix.green, old_pix.green);
    avg.blue   = chan_avg(now_pix.blue,  old_pix.blue);
  end

endmodule

>>> hdl/fdh_outq.sv
`timescale 1ns / 1ps

module fdh_outq import fdh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rgb_t                  push_data,
  input  logic                  pop,
  output rgb_t                  head,
  output logic                  not_empty,
  output logic [OUTQ_CNT_W-1:0] count
);

  rgb_t                  slots [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;

  function automatic logic [OUTQ_PTR_W-1:0] ptr_inc(input logic [OUTQ_PTR_W-1:0] p);
    begin
      ptr_inc = (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + 1'b1;
    end
  endfunction

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
